@@ hdl/fsa_pkg.sv @@
// fsa_pkg: shared types, codes and helpers for the fault status aggregator
package fsa_pkg;

  // widest slot index the table supports (up to sixteen slots)
  localparam int SLOT_IDX_MAX_W = 4;

  // module status codes
  localparam logic [2:0] MS_UNKNOWN  = 3'd0;
  localparam logic [2:0] MS_OK       = 3'd1;
  localparam logic [2:0] MS_WARNING  = 3'd2;
  localparam logic [2:0] MS_ERROR    = 3'd3;
  localparam logic [2:0] MS_INACTIVE = 3'd4;

  // connection status codes
  localparam logic [1:0] CN_UNKNOWN      = 2'd0;
  localparam logic [1:0] CN_DISCONNECTED = 2'd1;
  localparam logic [1:0] CN_CONNECTING   = 2'd2;
  localparam logic [1:0] CN_CONNECTED    = 2'd3;

  // overall status codes
  localparam logic [1:0] OV_UNKNOWN = 2'd0;
  localparam logic [1:0] OV_OK      = 2'd1;
  localparam logic [1:0] OV_WARNING = 2'd2;
  localparam logic [1:0] OV_ERROR   = 2'd3;

  // reason kinds
  localparam logic [3:0] RK_NONE          = 4'd0;
  localparam logic [3:0] RK_LINK_OFFLINE  = 4'd1;
  localparam logic [3:0] RK_MOD_ERROR     = 4'd2;
  localparam logic [3:0] RK_SENSOR        = 4'd3;
  localparam logic [3:0] RK_OUTPUT        = 4'd4;
  localparam logic [3:0] RK_DOOR          = 4'd5;
  localparam logic [3:0] RK_MAINT         = 4'd6;
  localparam logic [3:0] RK_MOD_WARNING   = 4'd7;
  localparam logic [3:0] RK_WIRELESS      = 4'd8;
  localparam logic [3:0] RK_RECONNECTING  = 4'd9;
  localparam logic [3:0] RK_STARTUP       = 4'd10;
  localparam logic [3:0] RK_GIVEN_ERROR   = 4'd11;
  localparam logic [3:0] RK_GIVEN_WARNING = 4'd12;

  // affected subsystem codes
  localparam logic [3:0] AF_NONE       = 4'd0;
  localparam logic [3:0] AF_CLIMATE    = 4'd1;
  localparam logic [3:0] AF_POT        = 4'd2;
  localparam logic [3:0] AF_LIGHT      = 4'd3;
  localparam logic [3:0] AF_FAN        = 4'd4;
  localparam logic [3:0] AF_HUMIDIFIER = 4'd5;
  localparam logic [3:0] AF_DOOR       = 4'd6;
  localparam logic [3:0] AF_SYSTEM     = 4'd7;
  localparam logic [3:0] AF_CONNECTION = 4'd8;

  // grace register limits
  localparam logic [5:0] GRACE_MAX = 6'd60;
  localparam logic [9:0] MS_PER_S  = 10'd1000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LINK,
    ST_SCAN,
    ST_RESPOND
  } fsa_state_t;

  // input item
  typedef struct packed {
    logic        mode;
    logic [2:0]  slot_index;
    logic [2:0]  module_state;
    logic [7:0]  module_reason;
    logic        sensor_gone;
    logic        output_broken;
    logic [63:0] time_ms;
    logic        door_is_open;
    logic        maintenance_on;
    logic [1:0]  wireless_state;
    logic [1:0]  link_state;
  } item_t;

  // result item
  typedef struct packed {
    logic       rejected;
    logic [1:0] overall;
    logic [3:0] reason_kind;
    logic [7:0] reason_from_module;
    logic [3:0] affected;
    logic [3:0] main_fault;
    logic       any_sensor_gone;
    logic       any_output_broken;
  } result_t;

  // slot table write request
  typedef struct packed {
    logic                      en;
    logic [SLOT_IDX_MAX_W-1:0] idx;
    logic [2:0]                state;
    logic                      since_en;
    logic [63:0]               since;
    logic [7:0]                reason;
    logic                      sensor_gone;
    logic                      output_broken;
  } slot_wr_t;

  // slot table read data
  typedef struct packed {
    logic [2:0]  state;
    logic [63:0] since;
    logic [7:0]  reason;
    logic        sensor_gone;
    logic        output_broken;
  } slot_rd_t;

  // subsystem served by a slot
  function automatic logic [3:0] slot_affected(input logic [SLOT_IDX_MAX_W-1:0] s);
    logic [3:0] a;
    case (s)
      4'd0:       a = AF_CLIMATE;
      4'd1, 4'd2: a = AF_POT;
      4'd3:       a = AF_LIGHT;
      4'd4:       a = AF_FAN;
      4'd5:       a = AF_HUMIDIFIER;
      4'd6:       a = AF_DOOR;
      default:    a = AF_SYSTEM;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/fsa_slot_table.sv @@
// fsa_slot_table: per-slot status, since-time, reason and fault flags
module fsa_slot_table #(
  parameter int MODULE_SLOTS = 7,
  parameter int IDX_W        = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  fsa_pkg::slot_wr_t wr,
  input  logic [IDX_W-1:0]  rd_idx,
  output fsa_pkg::slot_rd_t rd
);
  import fsa_pkg::*;

  logic [2:0]  slot_state       [MODULE_SLOTS];
  logic [63:0] slot_since       [MODULE_SLOTS];
  logic [7:0]  slot_reason      [MODULE_SLOTS];
  logic        slot_sensor_flag [MODULE_SLOTS];
  logic        slot_output_flag [MODULE_SLOTS];

  logic [IDX_W-1:0] wr_idx;

  assign wr_idx = wr.idx[IDX_W-1:0];

  // slot writes, since-time only on a status change
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MODULE_SLOTS; i++) begin
        slot_state[i]       <= MS_UNKNOWN;
        slot_since[i]       <= '0;
        slot_reason[i]      <= '0;
        slot_sensor_flag[i] <= 1'b0;
        slot_output_flag[i] <= 1'b0;
      end
    end else if (wr.en) begin
      slot_state[wr_idx]       <= wr.state;
      slot_reason[wr_idx]      <= wr.reason;
      slot_sensor_flag[wr_idx] <= wr.sensor_gone;
      slot_output_flag[wr_idx] <= wr.output_broken;
      if (wr.since_en) begin
        slot_since[wr_idx] <= wr.since;
      end
    end
  end

  // single read port
  always_comb begin
    rd.state         = slot_state[rd_idx];
    rd.since         = slot_since[rd_idx];
    rd.reason        = slot_reason[rd_idx];
    rd.sensor_gone   = slot_sensor_flag[rd_idx];
    rd.output_broken = slot_output_flag[rd_idx];
  end

endmodule

@@ hdl/fault_status_aggregator.sv @@
// fault_status_aggregator: module slot table, link timer and status priority chain
//
//  channel   | signals                      | direction | contents
//  ----------+------------------------------+-----------+---------------------------
//  cmd       | cmd_valid, cmd_stall, cmd    | in        | update or evaluate item
//  rsp       | rsp_valid, rsp_stall, rsp    | out       | status result item
//  grace     | grace_we, grace_wdata        | in        | link grace seconds register
//
// An update item passes from acceptance through a slot read and write, then a
// result load. An evaluate item passes through the link timer, a scan of each
// slot in turn through the shared 64-bit comparator, and the priority chain.
// Synchronous active-high reset clears the slot table, link tracking, grace
// register and sets the held result to startup unknown. cmd_stall is high while
// an item is at work; a stalled result waits in the output register and the
// next item may already be accepted.
module fault_status_aggregator #(
  parameter int MODULE_SLOTS = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  fsa_pkg::item_t   cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output fsa_pkg::result_t rsp,
  input  logic             grace_we,
  input  logic [5:0]       grace_wdata
);
  import fsa_pkg::*;

  localparam int IDX_W = (MODULE_SLOTS > 1) ? $clog2(MODULE_SLOTS) : 1;

  fsa_state_t state, state_next;

  item_t       item;
  logic [5:0]  grace;
  logic [1:0]  last_link_state;
  logic [63:0] link_since;
  logic        link_seen;
  result_t     held;

  // scan accumulators
  logic [IDX_W-1:0] cnt;
  logic             offline;
  logic             any_sensor, any_output, saw_unknown;
  logic             err_found, warn_found;
  logic [IDX_W-1:0] err_idx, warn_idx;
  logic [63:0]      best_err, best_warn;
  logic [7:0]       err_reason, warn_reason;

  // slot table ports
  slot_wr_t         wr;
  slot_rd_t         rd;
  logic [IDX_W-1:0] rd_idx;

  // shared comparator
  logic [63:0] cmp_a, cmp_b;
  logic        cmp_le;

  logic        is_eval, upd_invalid, scan_last, rsp_free;
  logic        link_changed, reconnecting;
  logic [15:0] grace_ms;
  logic [63:0] elapsed;
  logic        take_err, take_warn;
  result_t     snap;

  fsa_slot_table #(
    .MODULE_SLOTS (MODULE_SLOTS),
    .IDX_W        (IDX_W)
  ) u_slots (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  assign is_eval      = item.mode;
  assign upd_invalid  = (5'(item.slot_index) >= 5'(MODULE_SLOTS)) ||
                        (item.module_state > MS_INACTIVE);
  assign scan_last    = (cnt == IDX_W'(MODULE_SLOTS - 1));
  assign rsp_free     = !rsp_valid || !rsp_stall;
  assign cmd_stall    = (state != ST_IDLE);
  assign cmp_le       = (cmp_a <= cmp_b);
  assign link_changed = !link_seen || (last_link_state != item.link_state);
  assign reconnecting = (item.link_state == CN_CONNECTING) ||
                        (item.link_state == CN_DISCONNECTED);
  assign grace_ms     = 16'(grace) * 16'(MS_PER_S);
  assign elapsed      = link_changed ? 64'd0 : (item.time_ms - link_since);
  assign take_err     = (rd.state == MS_ERROR) && (!err_found || cmp_le);
  assign take_warn    = (rd.state == MS_WARNING) && (!warn_found || cmp_le);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.mode ? ST_LINK : ST_UPDATE;
        end
      end
      ST_UPDATE:  state_next = ST_RESPOND;
      ST_LINK:    state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_RESPOND;
        end
      end
      ST_RESPOND: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: table access and comparator operands
  always_comb begin
    rd_idx = cnt;
    wr     = '0;
    cmp_a  = rd.since;
    cmp_b  = (rd.state == MS_ERROR) ? best_err : best_warn;
    case (state)
      ST_UPDATE: begin
        rd_idx           = IDX_W'(item.slot_index);
        wr.en            = !upd_invalid;
        wr.idx           = SLOT_IDX_MAX_W'(item.slot_index);
        wr.state         = item.module_state;
        wr.since_en      = (rd.state != item.module_state);
        wr.since         = item.time_ms;
        wr.reason        = item.module_reason;
        wr.sensor_gone   = item.sensor_gone;
        wr.output_broken = item.output_broken;
      end
      ST_LINK: begin
        cmp_a = elapsed;
        cmp_b = 64'(grace_ms);
      end
      default: begin
      end
    endcase
  end

  // priority chain
  always_comb begin
    snap = held;
    if (is_eval) begin
      snap.rejected           = 1'b0;
      snap.overall            = OV_OK;
      snap.reason_kind        = RK_NONE;
      snap.reason_from_module = '0;
      snap.affected           = AF_NONE;
      snap.any_sensor_gone    = any_sensor;
      snap.any_output_broken  = any_output;
      if (offline) begin
        snap.overall     = OV_ERROR;
        snap.reason_kind = RK_LINK_OFFLINE;
        snap.affected    = AF_CONNECTION;
      end else if (err_found) begin
        snap.overall            = OV_ERROR;
        snap.reason_kind        = (err_reason != 8'd0) ? RK_GIVEN_ERROR : RK_MOD_ERROR;
        snap.reason_from_module = err_reason;
        snap.affected           = slot_affected(SLOT_IDX_MAX_W'(err_idx));
      end else if (any_sensor) begin
        snap.overall     = OV_ERROR;
        snap.reason_kind = RK_SENSOR;
        snap.affected    = AF_SYSTEM;
      end else if (any_output) begin
        snap.overall     = OV_ERROR;
        snap.reason_kind = RK_OUTPUT;
        snap.affected    = AF_SYSTEM;
      end else if (item.door_is_open) begin
        snap.overall     = OV_WARNING;
        snap.reason_kind = RK_DOOR;
        snap.affected    = AF_DOOR;
      end else if (item.maintenance_on) begin
        snap.overall     = OV_WARNING;
        snap.reason_kind = RK_MAINT;
        snap.affected    = AF_SYSTEM;
      end else if (warn_found) begin
        snap.overall            = OV_WARNING;
        snap.reason_kind        = (warn_reason != 8'd0) ? RK_GIVEN_WARNING : RK_MOD_WARNING;
        snap.reason_from_module = warn_reason;
        snap.affected           = slot_affected(SLOT_IDX_MAX_W'(warn_idx));
      end else if ((item.wireless_state == CN_DISCONNECTED) ||
                   (item.wireless_state == CN_CONNECTING)) begin
        snap.overall     = OV_WARNING;
        snap.reason_kind = RK_WIRELESS;
        snap.affected    = AF_CONNECTION;
      end else if (reconnecting) begin
        snap.overall     = OV_WARNING;
        snap.reason_kind = RK_RECONNECTING;
        snap.affected    = AF_CONNECTION;
      end else if (saw_unknown || (item.wireless_state == CN_UNKNOWN) ||
                   (item.link_state == CN_UNKNOWN)) begin
        snap.overall     = OV_UNKNOWN;
        snap.reason_kind = RK_STARTUP;
        snap.affected    = AF_NONE;
      end
      snap.main_fault = (snap.overall == OV_ERROR) ? snap.affected : AF_NONE;
    end else begin
      snap.rejected = upd_invalid;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // grace register, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      grace <= '0;
    end else if (grace_we) begin
      grace <= (grace_wdata > GRACE_MAX) ? GRACE_MAX : grace_wdata;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      item <= cmd;
    end
  end

  // link tracking and offline decision
  always_ff @(posedge clk) begin
    if (rst) begin
      last_link_state <= CN_UNKNOWN;
      link_since      <= '0;
      link_seen       <= 1'b0;
      offline         <= 1'b0;
    end else if (state == ST_LINK) begin
      if (link_changed) begin
        last_link_state <= item.link_state;
        link_since      <= item.time_ms;
        link_seen       <= 1'b1;
      end
      offline <= reconnecting && !cmp_le;
    end
  end

  // slot scan, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      any_sensor  <= 1'b0;
      any_output  <= 1'b0;
      saw_unknown <= 1'b0;
      err_found   <= 1'b0;
      warn_found  <= 1'b0;
    end else if (state == ST_LINK) begin
      cnt         <= '0;
      any_sensor  <= 1'b0;
      any_output  <= 1'b0;
      saw_unknown <= 1'b0;
      err_found   <= 1'b0;
      warn_found  <= 1'b0;
    end else if (state == ST_SCAN) begin
      cnt         <= cnt + 1'b1;
      any_sensor  <= any_sensor | rd.sensor_gone;
      any_output  <= any_output | rd.output_broken;
      saw_unknown <= saw_unknown | (rd.state == MS_UNKNOWN);
      if (take_err) begin
        err_found <= 1'b1;
      end
      if (take_warn) begin
        warn_found <= 1'b1;
      end
    end
  end

  // earliest candidates, payload only
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      if (take_err) begin
        err_idx    <= cnt;
        best_err   <= rd.since;
        err_reason <= rd.reason;
      end
      if (take_warn) begin
        warn_idx    <= cnt;
        best_warn   <= rd.since;
        warn_reason <= rd.reason;
      end
    end
  end

  // held result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid               <= 1'b0;
      held.rejected           <= 1'b0;
      held.overall            <= OV_UNKNOWN;
      held.reason_kind        <= RK_STARTUP;
      held.reason_from_module <= '0;
      held.affected           <= AF_NONE;
      held.main_fault         <= AF_NONE;
      held.any_sensor_gone    <= 1'b0;
      held.any_output_broken  <= 1'b0;
    end else if (state == ST_RESPOND && rsp_free) begin
      rsp_valid <= 1'b1;
      if (is_eval) begin
        held <= snap;
      end
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESPOND && rsp_free) begin
      rsp <= snap;
    end
  end

  // checks
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> (state != ST_IDLE))
    else $error("accepted item did not start the sequencer");

  a_main_error : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.main_fault == AF_NONE) || (rsp.overall == OV_ERROR)))
    else $error("main fault set without error status");

  a_load_from_respond : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_RESPOND))
    else $error("result loaded outside respond state");

  a_rejected_update : assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && upd_invalid) |-> !wr.en)
    else $error("invalid update wrote the slot table");

endmodule
